// ----- rtl/lbr_pkg.sv -----
// Shared constants and field widths for the letterbox bilinear resizer.
`timescale 1ns / 1ps

package lbr_pkg;

    // Default sizing of the source store, destination and weight precision
    localparam int MAX_SRC_W_DEF   = 1024;
    localparam int MAX_SRC_H_DEF   = 1024;
    localparam int MAX_DST_DIM_DEF = 1024;
    localparam int WEIGHT_BITS_DEF = 8;

    // Fixed port field widths
    localparam int CH_W      = 2;
    localparam int COL_W     = 10;
    localparam int ROW_W     = 10;
    localparam int PIX_W     = 8;
    localparam int LEVEL_W   = 16;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 2'd3;

    // Item function codes
    localparam logic FUNC_LOAD    = 1'b0;
    localparam logic FUNC_REQUEST = 1'b1;

    // Color plane code that carries no plane
    localparam logic [CH_W-1:0] CH_UNUSED = 2'd3;

    // Gray padding, 0.5 in the output scale
    localparam logic [LEVEL_W-1:0] PAD_LEVEL = 16'd32640;

    // Register values after reset
    localparam int RST_SRC_W = 640;
    localparam int RST_SRC_H = 480;
    localparam int RST_DST_W = 416;
    localparam int RST_DST_H = 416;

endpackage

// ----- rtl/letterbox_bilinear_resizer.sv -----
// Letterbox bilinear resizer top level: fit setup, item pipeline and source store.
// Throughput: one item per cycle once the fit setup is done, unless out_stall backs up
//   the pipeline; request results pass through the bit-per-stage position dividers.
// Loads write the store in item order at the read stage and produce no result.
// Reset (rst_n, async low) loads 640x480 -> 416x416 and runs the fit setup: in_stall
//   stays high through its product, divide, fit and offset states, and again after each
//   register write. The source store is not cleared.
`timescale 1ns / 1ps

module letterbox_bilinear_resizer #(
    parameter int MAX_SRC_W   = lbr_pkg::MAX_SRC_W_DEF,
    parameter int MAX_SRC_H   = lbr_pkg::MAX_SRC_H_DEF,
    parameter int MAX_DST_DIM = lbr_pkg::MAX_DST_DIM_DEF,
    parameter int WEIGHT_BITS = lbr_pkg::WEIGHT_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lbr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lbr_pkg::CFG_W-1:0]      cfg_data,

    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           func,
    input  logic [lbr_pkg::CH_W-1:0]       channel,
    input  logic [lbr_pkg::COL_W-1:0]      col_pos,
    input  logic [lbr_pkg::ROW_W-1:0]      row_pos,
    input  logic [lbr_pkg::PIX_W-1:0]      pixel_byte,

    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [lbr_pkg::CH_W-1:0]       out_channel,
    output logic [lbr_pkg::COL_W-1:0]      out_col,
    output logic [lbr_pkg::ROW_W-1:0]      out_row,
    output logic [lbr_pkg::LEVEL_W-1:0]    out_level,
    output logic                           is_padding
);

    // ------------------------------------------------------------------
    // Widths
    // ------------------------------------------------------------------
    localparam int SWW = $clog2(MAX_SRC_W + 1);
    localparam int SHW = $clog2(MAX_SRC_H + 1);
    localparam int DDW = $clog2(MAX_DST_DIM + 1);
    localparam int SMW = (SWW > SHW) ? SWW : SHW;
    localparam int PW  = DDW + SMW;
    localparam int CPW = $clog2(PW + 1);

    localparam int QWX = (MAX_SRC_W > 1) ? $clog2(MAX_SRC_W) : 1;
    localparam int QWY = (MAX_SRC_H > 1) ? $clog2(MAX_SRC_H) : 1;
    localparam int QM  = (QWX > QWY) ? QWX : QWY;
    localparam int DB  = (MAX_DST_DIM > 1) ? $clog2(MAX_DST_DIM) : 1;
    localparam int WB  = WEIGHT_BITS;
    localparam int ND  = QM + WB;
    localparam int NWX = lbr_pkg::COL_W + QM;
    localparam int NWY = lbr_pkg::ROW_W + QM;
    localparam int GW  = ((DDW > lbr_pkg::COL_W) ? DDW : lbr_pkg::COL_W) + 1;

    localparam int PLANE = MAX_SRC_W * MAX_SRC_H;
    localparam int MEM_D = 3 * PLANE;
    localparam int AW    = $clog2(MEM_D);

    localparam int PAW = WB + 1 + lbr_pkg::PIX_W;
    localparam int HW  = WB + lbr_pkg::PIX_W;
    localparam int MW  = WB + 1 + HW;
    localparam int VW  = 2 * WB + lbr_pkg::PIX_W + 1;
    localparam int RW  = VW + 9;

    localparam logic [WB:0] ONE_W = {1'b1, {WB{1'b0}}};

    // Reset values, clamped to the configured maxima
    localparam int RST_SW = (lbr_pkg::RST_SRC_W > MAX_SRC_W)   ? MAX_SRC_W   : lbr_pkg::RST_SRC_W;
    localparam int RST_SH = (lbr_pkg::RST_SRC_H > MAX_SRC_H)   ? MAX_SRC_H   : lbr_pkg::RST_SRC_H;
    localparam int RST_DW = (lbr_pkg::RST_DST_W > MAX_DST_DIM) ? MAX_DST_DIM : lbr_pkg::RST_DST_W;
    localparam int RST_DH = (lbr_pkg::RST_DST_H > MAX_DST_DIM) ? MAX_DST_DIM : lbr_pkg::RST_DST_H;

    // Pipeline stage indexes
    localparam int PS_GEO  = 0;
    localparam int PS_NUM  = 1;
    localparam int PS_DIV0 = 2;
    localparam int PS_ADDR = PS_DIV0 + ND;
    localparam int PS_READ = PS_ADDR + 1;
    localparam int PS_WMUL = PS_READ + 1;
    localparam int PS_HSUM = PS_WMUL + 1;
    localparam int PS_VMUL = PS_HSUM + 1;
    localparam int PS_OUT  = PS_VMUL + 1;
    localparam int NT      = PS_OUT + 1;

    // Fit setup sequencer states
    localparam logic [2:0] CS_PROD = 3'd0;
    localparam logic [2:0] CS_DIV  = 3'd1;
    localparam logic [2:0] CS_FIT  = 3'd2;
    localparam logic [2:0] CS_OFF  = 3'd3;
    localparam logic [2:0] CS_RUN  = 3'd4;

    typedef struct packed {
        logic                         is_req;
        logic                         is_load;
        logic [lbr_pkg::CH_W-1:0]     ch;
        logic [lbr_pkg::COL_W-1:0]    col;
        logic [lbr_pkg::ROW_W-1:0]    row;
        logic [lbr_pkg::PIX_W-1:0]    pix;
        logic                         pad;
        logic                         xedge;
        logic                         yedge;
    } item_t;

    // ------------------------------------------------------------------
    // Configuration registers and fit setup
    // ------------------------------------------------------------------
    logic [SWW-1:0] sw_reg, sw_wr;
    logic [SHW-1:0] sh_reg, sh_wr;
    logic [DDW-1:0] dw_reg, dh_reg, dw_wr, dh_wr;
    logic [2:0]     state_reg;
    logic [CPW-1:0] cnt_reg;

    logic           wide_reg;
    logic [PW-1:0]  p1, p2;
    logic [PW-1:0]  dnum_reg, dquo_reg;
    logic [SMW-1:0] dden_reg, drem_reg;
    logic [SMW:0]   dtrial;
    logic           dge;

    logic [DDW-1:0] new_w_reg, new_h_reg, off_x_reg, off_y_reg;
    logic [DB-1:0]  divx_reg, divy_reg;
    logic           xzero_reg, yzero_reg, sw_one_reg, sh_one_reg;
    logic [QM-1:0]  sw_m1_reg, sh_m1_reg;

    // A zero counts as one, anything above the maximum as the maximum
    always_comb
    begin
        if (cfg_data == '0)
            sw_wr = SWW'(1);
        else if (32'(cfg_data) > 32'(MAX_SRC_W))
            sw_wr = SWW'(MAX_SRC_W);
        else
            sw_wr = SWW'(cfg_data);

        if (cfg_data == '0)
            sh_wr = SHW'(1);
        else if (32'(cfg_data) > 32'(MAX_SRC_H))
            sh_wr = SHW'(MAX_SRC_H);
        else
            sh_wr = SHW'(cfg_data);

        if (cfg_data == '0)
            dw_wr = DDW'(1);
        else if (32'(cfg_data) > 32'(MAX_DST_DIM))
            dw_wr = DDW'(MAX_DST_DIM);
        else
            dw_wr = DDW'(cfg_data);
        dh_wr = dw_wr;
    end

    assign cfg_ready = 1'b1;

    // Cross products decide which side of the destination is filled
    assign p1     = PW'(dw_reg) * PW'(sh_reg);
    assign p2     = PW'(dh_reg) * PW'(sw_reg);
    assign dtrial = {drem_reg, dnum_reg[PW-1]};
    assign dge    = (dtrial >= {1'b0, dden_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sw_reg    <= SWW'(RST_SW);
            sh_reg    <= SHW'(RST_SH);
            dw_reg    <= DDW'(RST_DW);
            dh_reg    <= DDW'(RST_DH);
            state_reg <= CS_PROD;
            cnt_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            // Any write restarts the fit setup
            case (cfg_index)
                lbr_pkg::REG_SRC_WIDTH:  sw_reg <= sw_wr;
                lbr_pkg::REG_SRC_HEIGHT: sh_reg <= sh_wr;
                lbr_pkg::REG_DST_WIDTH:  dw_reg <= dw_wr;
                lbr_pkg::REG_DST_HEIGHT: dh_reg <= dh_wr;
                default: ;
            endcase
            state_reg <= CS_PROD;
            cnt_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                CS_PROD:
                begin
                    state_reg <= CS_DIV;
                    cnt_reg   <= '0;
                end
                CS_DIV:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CPW'(PW - 1))
                        state_reg <= CS_FIT;
                end
                CS_FIT:  state_reg <= CS_OFF;
                CS_OFF:  state_reg <= CS_RUN;
                CS_RUN:  state_reg <= CS_RUN;
                default: state_reg <= CS_PROD;
            endcase
        end
    end

    // Fit values: serial divide of the cross product, then offsets and divisors
    always_ff @(posedge clk)
    begin
        case (state_reg)
            CS_PROD:
            begin
                wide_reg <= (p1 < p2);
                dnum_reg <= (p1 < p2) ? p1 : p2;
                dden_reg <= (p1 < p2) ? SMW'(sw_reg) : SMW'(sh_reg);
                drem_reg <= '0;
                dquo_reg <= '0;
            end
            CS_DIV:
            begin
                drem_reg <= dge ? SMW'(dtrial - {1'b0, dden_reg}) : SMW'(dtrial);
                dnum_reg <= dnum_reg << 1;
                dquo_reg <= {dquo_reg[PW-2:0], dge};
            end
            CS_FIT:
            begin
                new_w_reg <= wide_reg ? dw_reg : DDW'(dquo_reg);
                new_h_reg <= wide_reg ? DDW'(dquo_reg) : dh_reg;
            end
            CS_OFF:
            begin
                off_x_reg  <= (dw_reg - new_w_reg) >> 1;
                off_y_reg  <= (dh_reg - new_h_reg) >> 1;
                xzero_reg  <= (new_w_reg <= DDW'(1));
                yzero_reg  <= (new_h_reg <= DDW'(1));
                divx_reg   <= (new_w_reg <= DDW'(1)) ? DB'(1) : DB'(new_w_reg - 1'b1);
                divy_reg   <= (new_h_reg <= DDW'(1)) ? DB'(1) : DB'(new_h_reg - 1'b1);
                sw_m1_reg  <= QM'(sw_reg - 1'b1);
                sh_m1_reg  <= QM'(sh_reg - 1'b1);
                sw_one_reg <= (sw_reg == SWW'(1));
                sh_one_reg <= (sh_reg == SHW'(1));
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Item pipeline control: a stage loads when it is empty or moving on
    // ------------------------------------------------------------------
    logic [NT:0]   ld;
    logic [NT-1:0] v_reg, v_next;
    item_t         side_reg [NT];
    item_t         side0;
    logic          accept;

    assign ld[NT] = !out_stall;

    genvar k;
    generate
        for (k = 0; k < NT; k++)
        begin : g_ld
            assign ld[k] = !v_reg[k] || ld[k+1];
        end
    endgenerate

    assign in_stall = (state_reg != CS_RUN) || !ld[0];
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        v_next = {v_reg[NT-2:0], accept && (side0.is_req || side0.is_load)};
        // Loads retire at the store, only requests go on
        v_next[PS_READ] = v_reg[PS_ADDR] && side_reg[PS_ADDR].is_req;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            for (int i = 0; i < NT; i++)
            begin
                if (ld[i])
                    v_reg[i] <= v_next[i];
            end
        end
    end

    generate
        for (k = 0; k < NT; k++)
        begin : g_side
            always_ff @(posedge clk)
            begin
                if (ld[k])
                begin
                    if (k == 0)
                        side_reg[k] <= side0;
                    else
                        side_reg[k] <= side_reg[(k == 0) ? 0 : k - 1];
                end
            end
        end
    endgenerate

    // ------------------------------------------------------------------
    // Stage GEO: decode, padding test, position inside the fitted area
    // ------------------------------------------------------------------
    logic [GW-1:0]              gcol, grow, gx, gy;
    logic [lbr_pkg::COL_W-1:0]  x0_reg;
    logic [lbr_pkg::ROW_W-1:0]  y0_reg;
    logic                       ch_ok;

    always_comb
    begin
        ch_ok = (channel != lbr_pkg::CH_UNUSED);
        gcol  = GW'(col_pos);
        grow  = GW'(row_pos);
        gx    = gcol - GW'(off_x_reg);
        gy    = grow - GW'(off_y_reg);

        side0.is_req  = (func == lbr_pkg::FUNC_REQUEST) && ch_ok;
        side0.is_load = (func == lbr_pkg::FUNC_LOAD) && ch_ok
                        && (32'(col_pos) < 32'(MAX_SRC_W))
                        && (32'(row_pos) < 32'(MAX_SRC_H));
        side0.ch      = channel;
        side0.col     = col_pos;
        side0.row     = row_pos;
        side0.pix     = pixel_byte;
        side0.pad     = (gcol >= GW'(dw_reg)) || (grow >= GW'(dh_reg))
                        || (gcol < GW'(off_x_reg))
                        || (gcol >= GW'(off_x_reg) + GW'(new_w_reg))
                        || (grow < GW'(off_y_reg))
                        || (grow >= GW'(off_y_reg) + GW'(new_h_reg));
        side0.xedge   = (gx == GW'(new_w_reg) - 1'b1) || sw_one_reg;
        side0.yedge   = (gy == GW'(new_h_reg) - 1'b1) || sh_one_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ld[PS_GEO])
        begin
            x0_reg <= gx[lbr_pkg::COL_W-1:0];
            y0_reg <= gy[lbr_pkg::ROW_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage NUM: position times source span; zero it for padding or where it would not divide
    // ------------------------------------------------------------------
    logic [NWX-1:0] numx_reg;
    logic [NWY-1:0] numy_reg;

    always_ff @(posedge clk)
    begin
        if (ld[PS_NUM])
        begin
            numx_reg <= (xzero_reg || side_reg[PS_GEO].pad) ? '0
                        : NWX'(x0_reg) * NWX'(sw_m1_reg);
            numy_reg <= (yzero_reg || side_reg[PS_GEO].pad) ? '0
                        : NWY'(y0_reg) * NWY'(sh_m1_reg);
        end
    end

    // ------------------------------------------------------------------
    // Division stages: source index and truncated weight per axis
    // ------------------------------------------------------------------
    logic [QM-1:0] ix, iy;
    logic [WB-1:0] dx, dy;

    lbr_div_pipe #(.QB(QM), .FB(WB), .DB(DB), .NW(NWX)) u_div_x (
        .clk  (clk),
        .ld   (ld[PS_DIV0 +: ND]),
        .num  (numx_reg),
        .den  (divx_reg),
        .quo  (ix),
        .frac (dx)
    );

    lbr_div_pipe #(.QB(QM), .FB(WB), .DB(DB), .NW(NWY)) u_div_y (
        .clk  (clk),
        .ld   (ld[PS_DIV0 +: ND]),
        .num  (numy_reg),
        .den  (divy_reg),
        .quo  (iy),
        .frac (dy)
    );

    // ------------------------------------------------------------------
    // Stage ADDR: neighbor addresses and weights, edge and padding cases
    // ------------------------------------------------------------------
    item_t         ia;
    logic [QM-1:0] c0, c1, r0, r1;
    logic [WB-1:0] wx;
    logic [WB:0]   wy0, wy1;
    logic [AW-1:0] base, a00, a01, a10, a11, la;
    logic [AW-1:0] a00_reg, a01_reg, a10_reg, a11_reg;
    logic [WB-1:0] wx_reg;
    logic [WB:0]   wy0_reg, wy1_reg;

    always_comb
    begin
        ia = side_reg[PS_ADDR-1];
        // Last fitted column or a one-pixel-wide source: edge sample alone
        if (ia.xedge)
        begin
            c0 = sw_m1_reg;
            c1 = sw_m1_reg;
            wx = '0;
        end
        else
        begin
            c0 = ix;
            c1 = ix + 1'b1;
            wx = dx;
        end
        // Last fitted row or one-pixel-high source: first row only, scaled by one minus dy
        r0  = iy;
        r1  = ia.yedge ? iy : iy + 1'b1;
        wy0 = ONE_W - {1'b0, dy};
        wy1 = ia.yedge ? '0 : {1'b0, dy};
        if (ia.pad)
        begin
            c0 = '0;
            c1 = '0;
            r0 = '0;
            r1 = '0;
        end
        base = AW'(ia.ch) * AW'(PLANE);
        la   = base + AW'(ia.row) * AW'(MAX_SRC_W) + AW'(ia.col);
        a00  = ia.is_load ? la : base + AW'(r0) * AW'(MAX_SRC_W) + AW'(c0);
        a01  = base + AW'(r0) * AW'(MAX_SRC_W) + AW'(c1);
        a10  = base + AW'(r1) * AW'(MAX_SRC_W) + AW'(c0);
        a11  = base + AW'(r1) * AW'(MAX_SRC_W) + AW'(c1);
    end

    always_ff @(posedge clk)
    begin
        if (ld[PS_ADDR])
        begin
            a00_reg <= a00;
            a01_reg <= a01;
            a10_reg <= a10;
            a11_reg <= a11;
            wx_reg  <= wx;
            wy0_reg <= wy0;
            wy1_reg <= wy1;
        end
    end

    // ------------------------------------------------------------------
    // Stage READ: source store, two copies with two read ports each
    // ------------------------------------------------------------------
    logic [lbr_pkg::PIX_W-1:0] mem_a [MEM_D];
    logic [lbr_pkg::PIX_W-1:0] mem_b [MEM_D];
    logic [lbr_pkg::PIX_W-1:0] d00_reg, d01_reg, d10_reg, d11_reg;
    logic [WB-1:0]             wx_r_reg;
    logic [WB:0]               wy0_r_reg, wy1_r_reg;

    always_ff @(posedge clk)
    begin
        if (ld[PS_READ])
        begin
            // Loads land here in item order, so later requests see them
            if (v_reg[PS_ADDR] && side_reg[PS_ADDR].is_load)
            begin
                mem_a[a00_reg] <= side_reg[PS_ADDR].pix;
                mem_b[a00_reg] <= side_reg[PS_ADDR].pix;
            end
            d00_reg   <= mem_a[a00_reg];
            d01_reg   <= mem_a[a01_reg];
            d10_reg   <= mem_b[a10_reg];
            d11_reg   <= mem_b[a11_reg];
            wx_r_reg  <= wx_reg;
            wy0_r_reg <= wy0_reg;
            wy1_r_reg <= wy1_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stages WMUL, HSUM: horizontal pass on both rows
    // ------------------------------------------------------------------
    logic [PAW-1:0] pa0_reg, pa1_reg, pb0_reg, pb1_reg;
    logic [WB:0]    wy0_m_reg, wy1_m_reg, wy0_h_reg, wy1_h_reg;
    logic [HW-1:0]  h0_reg, h1_reg;

    always_ff @(posedge clk)
    begin
        if (ld[PS_WMUL])
        begin
            pa0_reg   <= PAW'(ONE_W - {1'b0, wx_r_reg}) * PAW'(d00_reg);
            pa1_reg   <= PAW'(wx_r_reg) * PAW'(d01_reg);
            pb0_reg   <= PAW'(ONE_W - {1'b0, wx_r_reg}) * PAW'(d10_reg);
            pb1_reg   <= PAW'(wx_r_reg) * PAW'(d11_reg);
            wy0_m_reg <= wy0_r_reg;
            wy1_m_reg <= wy1_r_reg;
        end
        if (ld[PS_HSUM])
        begin
            h0_reg    <= HW'(pa0_reg + pa1_reg);
            h1_reg    <= HW'(pb0_reg + pb1_reg);
            wy0_h_reg <= wy0_m_reg;
            wy1_h_reg <= wy1_m_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stages VMUL, OUT: vertical pass, round to the output scale
    // ------------------------------------------------------------------
    logic [MW-1:0]               m0_reg, m1_reg;
    logic [VW-1:0]               vsum;
    logic [RW-1:0]               vround;
    logic [lbr_pkg::LEVEL_W-1:0] level_reg;

    assign vsum   = VW'(m0_reg) + VW'(m1_reg);
    assign vround = (RW'(vsum) << 8) + (RW'(1) << (2 * WB - 1));

    always_ff @(posedge clk)
    begin
        if (ld[PS_VMUL])
        begin
            m0_reg <= MW'(wy0_h_reg) * MW'(h0_reg);
            m1_reg <= MW'(wy1_h_reg) * MW'(h1_reg);
        end
        if (ld[PS_OUT])
        begin
            level_reg <= side_reg[PS_VMUL].pad ? lbr_pkg::PAD_LEVEL
                         : lbr_pkg::LEVEL_W'(vround >> (2 * WB));
        end
    end

    // Result item straight from the output register
    assign out_valid   = v_reg[PS_OUT];
    assign out_channel = side_reg[PS_OUT].ch;
    assign out_col     = side_reg[PS_OUT].col;
    assign out_row     = side_reg[PS_OUT].row;
    assign out_level   = level_reg;
    assign is_padding  = side_reg[PS_OUT].pad;

endmodule

// ----- rtl/lbr_div_pipe.sv -----
// Pipelined restoring divider: one quotient bit per stage, integer then fraction bits.
`timescale 1ns / 1ps

module lbr_div_pipe #(
    parameter int QB = 10,
    parameter int FB = 8,
    parameter int DB = 10,
    parameter int NW = 20
) (
    input  logic                 clk,
    input  logic [QB+FB-1:0]     ld,
    input  logic [NW-1:0]        num,
    input  logic [DB-1:0]        den,
    output logic [QB-1:0]        quo,
    output logic [FB-1:0]        frac
);

    localparam int NS = QB + FB;

    logic [DB-1:0]    rem_reg [NS];
    logic [DB-1:0]    den_reg [NS];
    logic [QB-1:0]    low_reg [NS];
    logic [NS-1:0]    q_reg   [NS];
    logic [NW+DB-1:0] num_hi;

    // Quotient fits in QB bits, so the high part is already below the divisor
    assign num_hi = {{DB{1'b0}}, num} >> QB;

    genvar k;
    generate
        for (k = 0; k < NS; k++)
        begin : g_stage
            logic [DB-1:0] rem_in;
            logic [DB-1:0] den_in;
            logic [QB-1:0] low_in;
            logic [NS-1:0] q_in;
            logic          nbit;
            logic [DB:0]   trial;
            logic          ge;

            if (k == 0)
            begin : g_first
                assign rem_in = num_hi[DB-1:0];
                assign den_in = den;
                assign low_in = num[QB-1:0];
                assign q_in   = '0;
            end
            else
            begin : g_next
                assign rem_in = rem_reg[k-1];
                assign den_in = den_reg[k-1];
                assign low_in = low_reg[k-1];
                assign q_in   = q_reg[k-1];
            end

            // Bring down numerator bits first, then zeros for the fraction
            if (k < QB)
            begin : g_int
                assign nbit = low_in[QB-1];
            end
            else
            begin : g_frac
                assign nbit = 1'b0;
            end

            assign trial = {rem_in, nbit};
            assign ge    = (trial >= {1'b0, den_in});

            always_ff @(posedge clk)
            begin
                if (ld[k])
                begin
                    rem_reg[k] <= ge ? DB'(trial - {1'b0, den_in}) : DB'(trial);
                    den_reg[k] <= den_in;
                    low_reg[k] <= low_in << 1;
                    q_reg[k]   <= {q_in[NS-2:0], ge};
                end
            end
        end
    endgenerate

    assign quo  = q_reg[NS-1][NS-1:FB];
    assign frac = q_reg[NS-1][FB-1:0];

endmodule

// ----- bench/tb_letterbox_bilinear_resizer.sv -----
// Testbench for the letterbox bilinear resizer: random loads and requests against a predictor.
`timescale 1ns / 1ps

module tb_letterbox_bilinear_resizer;
    import lbr_pkg::*;

    // Run limit in clock cycles; far above the slowest correct run
    localparam int CYCLE_LIMIT = 1500000;
    // Idle time that covers the request pipeline and any load still in flight
    localparam int DRAIN_CYCLES = 60;
    localparam int ONE = 256;

    typedef struct {
        logic                 fn;
        logic [CH_W-1:0]      ch;
        logic [COL_W-1:0]     col;
        logic [ROW_W-1:0]     row;
        logic [PIX_W-1:0]     pix;
        bit                   has_res;
        logic [LEVEL_W-1:0]   lvl;
        logic                 pad;
    } px_item_t;

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;
    logic in_valid;
    logic in_stall;
    logic func;
    logic [CH_W-1:0] channel;
    logic [COL_W-1:0] col_pos;
    logic [ROW_W-1:0] row_pos;
    logic [PIX_W-1:0] pixel_byte;
    logic out_valid;
    logic out_stall;
    logic [CH_W-1:0] out_channel;
    logic [COL_W-1:0] out_col;
    logic [ROW_W-1:0] out_row;
    logic [LEVEL_W-1:0] out_level;
    logic is_padding;

    letterbox_bilinear_resizer dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .func(func), .channel(channel),
        .col_pos(col_pos), .row_pos(row_pos), .pixel_byte(pixel_byte),
        .out_valid(out_valid), .out_stall(out_stall), .out_channel(out_channel),
        .out_col(out_col), .out_row(out_row), .out_level(out_level),
        .is_padding(is_padding)
    );

    // Mirror of the register file, already clamped
    int unsigned src_w, src_h, dst_w, dst_h;
    // Mirror of the source store; only written entries exist
    byte unsigned src_mem[int];
    // Source samples a prediction needed but found unwritten
    int missing_addr[$];

    px_item_t pending_items[$];
    px_item_t expected_samples[$];
    int errors = 0;
    int accepted_cnt = 0;
    int cycles = 0;
    bit took_item = 0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int unsigned clamp_size(int unsigned v, int unsigned maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    function automatic int store_addr(int unsigned ch, int unsigned r, int unsigned c);
        return ch * 1048576 + r * 1024 + c;
    endfunction

    // Read one stored byte; note it as missing when never written
    function automatic longint unsigned stored_byte(int unsigned ch, int unsigned r,
                                                    int unsigned c);
        int a;
        a = store_addr(ch, r, c);
        if (src_mem.exists(a)) return src_mem[a];
        missing_addr.push_back(a);
        return 0;
    endfunction

    // Fitted size and centering offsets for the current registers
    function automatic void fit_area(output int unsigned nw, output int unsigned nh,
                                     output int unsigned ox, output int unsigned oy);
        if (dst_w * src_h < dst_h * src_w)
        begin
            nw = dst_w;
            nh = (src_h * dst_w) / src_w;
        end
        else
        begin
            nh = dst_h;
            nw = (src_w * dst_h) / src_h;
        end
        ox = (dst_w - nw) / 2;
        oy = (dst_h - nh) / 2;
    endfunction

    // Horizontal pass along one source row, scaled by ONE
    function automatic longint unsigned row_blend(int unsigned ch, int unsigned r,
                                                  int unsigned x, int unsigned nw);
        int unsigned dv, num, ix, rem;
        longint unsigned dx;
        if (x == nw - 1 || src_w == 1) return stored_byte(ch, r, src_w - 1) * ONE;
        dv = nw - 1;
        num = x * (src_w - 1);
        ix = num / dv;
        rem = num % dv;
        dx = (longint'(rem) * ONE) / dv;
        return (ONE - dx) * stored_byte(ch, r, ix) + dx * stored_byte(ch, r, ix + 1);
    endfunction

    function automatic void resize_sample(input int unsigned ch, input int unsigned col,
                                          input int unsigned row,
                                          output logic [LEVEL_W-1:0] lvl, output logic pad);
        int unsigned nw, nh, ox, oy, x, y, dv, num, iy, rem;
        longint unsigned dy, v;
        fit_area(nw, nh, ox, oy);
        pad = (col >= dst_w || row >= dst_h || col < ox || col >= ox + nw ||
               row < oy || row >= oy + nh);
        lvl = PAD_LEVEL;
        if (!pad)
        begin
            x = col - ox;
            y = row - oy;
            dv = nh - 1;
            iy = 0;
            dy = 0;
            if (dv != 0)
            begin
                num = y * (src_h - 1);
                iy = num / dv;
                rem = num % dv;
                dy = (longint'(rem) * ONE) / dv;
            end
            v = (ONE - dy) * row_blend(ch, iy, x, nw);
            if (!(y == nh - 1 || src_h == 1)) v += dy * row_blend(ch, iy + 1, x, nw);
            lvl = LEVEL_W'((v * 256 + 32768) >> 16);
        end
    endfunction

    task automatic queue_load(int unsigned ch, int unsigned col, int unsigned row,
                              int unsigned pix);
        px_item_t it;
        it = '{FUNC_LOAD, CH_W'(ch), COL_W'(col), ROW_W'(row), PIX_W'(pix), 0, '0, 1'b0};
        pending_items.push_back(it);
        if (ch != CH_UNUSED) src_mem[store_addr(ch, row, col)] = byte'(pix);
    endtask

    // Queue a request; first load every source sample it would read unwritten
    task automatic queue_request(int unsigned ch, int unsigned col, int unsigned row);
        px_item_t it;
        logic [LEVEL_W-1:0] lvl;
        logic pad;
        int a;
        it = '{FUNC_REQUEST, CH_W'(ch), COL_W'(col), ROW_W'(row),
               PIX_W'($urandom), 0, '0, 1'b0};
        if (ch != CH_UNUSED)
        begin
            missing_addr.delete();
            resize_sample(ch, col, row, lvl, pad);
            while (missing_addr.size() != 0)
            begin
                a = missing_addr.pop_front();
                if (!src_mem.exists(a))
                    queue_load(a / 1048576, a % 1024, (a / 1024) % 1024, $urandom_range(0, 255));
            end
            resize_sample(ch, col, row, lvl, pad);
            it.has_res = 1;
            it.lvl = lvl;
            it.pad = pad;
        end
        pending_items.push_back(it);
    endtask

    task automatic wait_idle();
        while (pending_items.size() != 0 || expected_samples.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_W'(val);
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            REG_SRC_WIDTH:  src_w = clamp_size(val, MAX_SRC_W_DEF);
            REG_SRC_HEIGHT: src_h = clamp_size(val, MAX_SRC_H_DEF);
            REG_DST_WIDTH:  dst_w = clamp_size(val, MAX_DST_DIM_DEF);
            default:        dst_h = clamp_size(val, MAX_DST_DIM_DEF);
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // One phase: directed corners and odd items, then a random mix
    task automatic run_phase(int n_items);
        int unsigned nw, nh, ox, oy, c, r, start;
        fit_area(nw, nh, ox, oy);
        start = pending_items.size();
        queue_load(CH_UNUSED, 5, 5, 255);
        queue_load(0, 0, 0, 0);
        queue_load(2, 1023, 1023, 255);
        queue_request(CH_UNUSED, 0, 0);
        queue_request(0, 1023, 1023);
        queue_request(1, 0, 0);
        queue_request(2, dst_w - 1, dst_h - 1);
        if (nw > 0 && nh > 0)
        begin
            queue_request(0, ox, oy);
            queue_request(1, ox + nw - 1, oy + nh - 1);
            queue_request(2, ox + nw - 1, oy);
        end
        while (pending_items.size() - start < n_items)
        begin
            case ($urandom_range(0, 9))
                0:
                    queue_load($urandom_range(0, 3), $urandom_range(0, 1023),
                               $urandom_range(0, 1023), $urandom_range(0, 255));
                1, 2:
                begin
                    c = $urandom_range(0, (src_w > 1024 ? 1024 : src_w) - 1);
                    r = $urandom_range(0, (src_h > 1024 ? 1024 : src_h) - 1);
                    queue_load($urandom_range(0, 2), c, r, $urandom_range(0, 255));
                end
                3:
                    queue_request($urandom_range(0, 3), $urandom_range(0, 1023),
                                  $urandom_range(0, 1023));
                default:
                    queue_request($urandom_range(0, 2), $urandom_range(0, dst_w - 1),
                                  $urandom_range(0, dst_h - 1));
            endcase
        end
        wait_idle();
    endtask

    task automatic config_phase(int unsigned sw, int unsigned sh, int unsigned dw,
                                int unsigned dh, int n_items);
        write_reg(REG_SRC_WIDTH, sw);
        write_reg(REG_SRC_HEIGHT, sh);
        write_reg(REG_DST_WIDTH, dw);
        write_reg(REG_DST_HEIGHT, dh);
        run_phase(n_items);
    endtask

    // Stimulus: reset, then a sequence of register settings
    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        func = FUNC_LOAD;
        channel = '0;
        col_pos = '0;
        row_pos = '0;
        pixel_byte = '0;
        out_stall = 1'b0;
        src_w = RST_SRC_W;
        src_h = RST_SRC_H;
        dst_w = RST_DST_W;
        dst_h = RST_DST_H;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        run_phase(150);
        // Zero registers count as one
        config_phase(0, 0, 0, 0, 60);
        // Oversized registers count as the maximum
        config_phase(2047, 2047, 2047, 2047, 120);
        // Fitted width collapses to zero: all padding
        config_phase(1, 1024, 8, 8, 60);
        // Source one pixel high
        config_phase(4, 1, 6, 6, 80);
        // Fitted height of one: zero row divisor
        config_phase(5, 3, 7, 1, 80);
        // Source one pixel wide, tall destination
        config_phase(1, 6, 9, 20, 80);
        config_phase(1024, 2, 40, 12, 80);
        repeat (6)
            config_phase($urandom_range(1, 9), $urandom_range(1, 9), $urandom_range(1, 12),
                         $urandom_range(1, 12), 90);

        wait_idle();
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Accept items, check results, watch the cycle limit
    always @(posedge clk)
    begin
        px_item_t it;
        px_item_t exp_s;
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        if (rst_n && in_valid && !in_stall)
        begin
            it = pending_items.pop_front();
            if (it.has_res) expected_samples.push_back(it);
            accepted_cnt++;
            took_item = 1;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_samples.size() == 0)
            begin
                $display("%0t: unexpected result ch=%0d col=%0d row=%0d level=%0d pad=%0d",
                         $time, out_channel, out_col, out_row, out_level, is_padding);
                errors++;
            end
            else
            begin
                exp_s = expected_samples.pop_front();
                if (out_channel !== exp_s.ch)
                begin
                    $display("%0t: out_channel expected %0d got %0d", $time, exp_s.ch,
                             out_channel);
                    errors++;
                end
                if (out_col !== exp_s.col)
                begin
                    $display("%0t: out_col expected %0d got %0d", $time, exp_s.col, out_col);
                    errors++;
                end
                if (out_row !== exp_s.row)
                begin
                    $display("%0t: out_row expected %0d got %0d", $time, exp_s.row, out_row);
                    errors++;
                end
                if (out_level !== exp_s.lvl)
                begin
                    $display("%0t: out_level at (%0d,%0d,%0d) expected %0d got %0d", $time,
                             exp_s.ch, exp_s.col, exp_s.row, exp_s.lvl, out_level);
                    errors++;
                end
                if (is_padding !== exp_s.pad)
                begin
                    $display("%0t: is_padding expected %0d got %0d", $time, exp_s.pad,
                             is_padding);
                    errors++;
                end
            end
        end
    end

    // Driver: bursts of items with random gaps; hold a stalled item
    int burst_left = 0;
    int gap_left = 0;

    always @(negedge clk)
    begin
        if (rst_n && !(in_valid && !took_item))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (pending_items.size() != 0)
            begin
                in_valid <= 1'b1;
                func <= pending_items[0].fn;
                channel <= pending_items[0].ch;
                col_pos <= pending_items[0].col;
                row_pos <= pending_items[0].row;
                pixel_byte <= pending_items[0].pix;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else
                in_valid <= 1'b0;
        end
        took_item = 0;
    end

    // Receiver: stall pattern of its own, plus one long hold-off mid-run
    int hold_left = 0;
    bit hold_done = 0;
    int stretch_left = 0;
    bit stall_mode = 0;

    always @(negedge clk)
    begin
        if (stretch_left == 0)
        begin
            stretch_left = $urandom_range(10, 200);
            stall_mode = $urandom_range(0, 1);
        end
        else
            stretch_left--;
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (!hold_done && accepted_cnt >= 400)
        begin
            hold_done = 1;
            hold_left = 300;
            out_stall <= 1'b1;
        end
        else
            out_stall <= stall_mode && ($urandom_range(0, 3) == 0);
    end

endmodule
